@@ sv/fip_pkg.sv @@
// Shared types, constants and helper functions of the fractal iteration palette.
`default_nettype none

package fip_pkg;

    // Palette codes, as written to the palette_select register
    typedef enum logic [1:0] {
        PAL_GALACTIC = 2'd0,
        PAL_RED      = 2'd1,
        PAL_PSYCHO   = 2'd2,
        PAL_BLACK    = 2'd3
    } palette_t;

    // Configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PALETTE_SELECT = 1'b0,
        CFG_MAX_ITERATIONS = 1'b1
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] MAX_ITER_RESET = 16'd100;

    // Packed color: red 23:16, green 15:8, blue 7:0
    localparam int COLOR_W = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t INTERIOR_GALACTIC = {8'd30, 8'd0, 8'd0};
    localparam rgb_t INTERIOR_RED      = {8'd141, 8'd26, 8'd187};
    localparam rgb_t INTERIOR_PSYCHO   = {8'd20, 8'd0, 8'd80};
    localparam rgb_t COLOR_BLACK       = {8'd0, 8'd0, 8'd0};

    // Bernstein weights scaled by 255 (blue carries 17/2, hence one extra shift)
    localparam int CONST_W = 13;
    localparam logic [CONST_W-1:0] K_RED   = 13'd2295;
    localparam logic [CONST_W-1:0] K_GREEN = 13'd3825;
    localparam logic [CONST_W-1:0] K_BLUE  = 13'd4335;

    // Channel step factors of the modular palettes
    localparam logic [7:0] RED_PAL_R_STEP = 8'd12;
    localparam logic [7:0] RED_PAL_B_STEP = 8'd6;
    localparam logic [7:0] PSY_PAL_R_STEP = 8'd128;
    localparam logic [7:0] PSY_PAL_B_STEP = 8'd64;

    // x mod 255: 256 is 1 mod 255, so bytes are folded together
    function automatic logic [7:0] mod255(input logic [15:0] x);
        logic [8:0] s1;
        logic [8:0] s2;
        s1 = {1'b0, x[7:0]} + {1'b0, x[15:8]};
        s2 = {1'b0, s1[7:0]} + {8'd0, s1[8]};
        mod255 = (s2[7:0] == 8'hFF) ? 8'd0 : s2[7:0];
    endfunction

    // (m * k) mod 255 for a residue m below 255
    function automatic logic [7:0] mod255_scaled(input logic [7:0] m, input logic [7:0] k);
        logic [15:0] prod;
        prod = {8'd0, m} * {8'd0, k};
        mod255_scaled = mod255(prod);
    endfunction

endpackage

`default_nettype wire

@@ sv/fip_iter_if.sv @@
// Stream interface carrying one escape-iteration count per transfer.
`default_nettype none

interface fip_iter_if #(
    parameter int ITER_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [ITER_BITS-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

@@ sv/fip_color_if.sv @@
// Stream interface carrying one packed RGB pixel color per transfer.
`default_nettype none

interface fip_color_if ();
    logic                         valid;
    logic                         ready;
    logic [fip_pkg::COLOR_W-1:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

@@ sv/fip_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, fraction quotient only.
`default_nettype none

module fip_divider #(
    parameter int ITER_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic [FRAC_BITS-1:0] en,
    input  wire logic [ITER_BITS:0]   dividend,
    input  wire logic [ITER_BITS:0]   divisor,
    output logic      [FRAC_BITS-1:0] quotient
);

    localparam int RW = ITER_BITS + 1;

    logic [RW-1:0]        rem_reg  [FRAC_BITS-1];
    logic [RW-1:0]        rem_next [FRAC_BITS-1];
    logic [FRAC_BITS-1:0] quo_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_next [FRAC_BITS];

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
        logic [RW-1:0]        rem_in;
        logic [FRAC_BITS-1:0] quo_in;
        logic [RW:0]          dbl;
        logic [RW:0]          diff;
        logic                 take;

        if (k == 0) begin : g_first
            assign rem_in = dividend;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // remainder stays below the divisor, so the doubled value fits RW+1 bits
        assign dbl  = {rem_in, 1'b0};
        assign take = (dbl >= {1'b0, divisor});
        assign diff = dbl - {1'b0, divisor};
        assign quo_next[k] = {quo_in[FRAC_BITS-2:0], take};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                quo_reg[k] <= quo_next[k];
            end
        end

        if (k < FRAC_BITS - 1) begin : g_keep
            assign rem_next[k] = take ? diff[RW-1:0] : dbl[RW-1:0];

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_next[k];
                end
            end
        end
    end

    assign quotient = quo_reg[FRAC_BITS-1];

endmodule

`default_nettype wire

@@ sv/fip_bernstein.sv @@
// Five-stage Bernstein color pipeline: exact fixed-point products, truncated and clamped to 8 bits.
`default_nettype none

module fip_bernstein #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic [4:0]           en,
    input  wire logic [FRAC_BITS-1:0] t,
    output fip_pkg::rgb_t             color
);

    localparam int F   = FRAC_BITS;
    localparam int QW  = 2 * F + 1;             // t^2, u*t, u^2
    localparam int KW  = QW + fip_pkg::CONST_W; // weight times square
    localparam int HW  = KW / 2;                // split point of the weighted term
    localparam int PW  = 2 * F;                 // u*t fits 2F bits
    localparam int PPW = HW + F;                // partial product
    localparam int XW  = PPW + F + 1;           // pair sums
    localparam int TW  = XW + HW + 1;           // full product

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam int PP_HH = 0;
    localparam int PP_HL = 1;
    localparam int PP_LH = 2;
    localparam int PP_LL = 3;

    localparam logic [fip_pkg::CONST_W-1:0] KCONST [3] =
        '{fip_pkg::K_RED, fip_pkg::K_GREEN, fip_pkg::K_BLUE};
    localparam int SHIFT [3] = '{4 * F, 4 * F, 4 * F + 1};

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [F:0]    u;
    logic [QW-1:0] t_x;
    logic [QW-1:0] u_x;

    logic [QW-1:0]  q_reg    [3];
    logic [QW-1:0]  q_next   [3];
    logic [KW-1:0]  k_reg    [3];
    logic [KW-1:0]  k_next   [3];
    logic [PW-1:0]  p_reg;
    logic [PPW-1:0] part_reg  [3][4];
    logic [PPW-1:0] part_next [3][4];
    logic [XW-1:0]  x_reg    [3];
    logic [XW-1:0]  x_next   [3];
    logic [XW-1:0]  y_reg    [3];
    logic [XW-1:0]  y_next   [3];
    logic [TW-1:0]  total    [3];
    logic [TW-1:0]  shifted  [3];
    logic [7:0]     chan     [3];
    fip_pkg::rgb_t  color_reg;
    fip_pkg::rgb_t  color_next;

    // E0: squares and cross term of t and u = 1 - t
    always_comb
    begin
        u   = ONE - {1'b0, t};
        t_x = QW'(t);
        u_x = QW'(u);
        q_next[CH_RED]   = t_x * t_x;
        q_next[CH_GREEN] = u_x * t_x;
        q_next[CH_BLUE]  = u_x * u_x;
    end

    // E1: scale by the channel weight
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            k_next[c] = KW'(KCONST[c]) * KW'(q_reg[c]);
        end
    end

    // E2: four partial products of weight term times u*t
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            part_next[c][PP_HH] = PPW'(k_reg[c][KW-1:HW]) * PPW'(p_reg[PW-1:F]);
            part_next[c][PP_HL] = PPW'(k_reg[c][KW-1:HW]) * PPW'(p_reg[F-1:0]);
            part_next[c][PP_LH] = PPW'(k_reg[c][HW-1:0])  * PPW'(p_reg[PW-1:F]);
            part_next[c][PP_LL] = PPW'(k_reg[c][HW-1:0])  * PPW'(p_reg[F-1:0]);
        end
    end

    // E3: pair sums
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            x_next[c] = (XW'(part_reg[c][PP_HH]) << F) + XW'(part_reg[c][PP_HL]);
            y_next[c] = (XW'(part_reg[c][PP_LH]) << F) + XW'(part_reg[c][PP_LL]);
        end
    end

    // E4: final sum, truncate, clamp
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            total[c]   = (TW'(x_reg[c]) << HW) + TW'(y_reg[c]);
            shifted[c] = total[c] >> SHIFT[c];
            chan[c]    = (|shifted[c][TW-1:8]) ? 8'hFF : shifted[c][7:0];
        end
        color_next = {chan[CH_RED], chan[CH_GREEN], chan[CH_BLUE]};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_reg <= q_next;
        end
        if (en[1])
        begin
            k_reg <= k_next;
            p_reg <= q_reg[CH_GREEN][PW-1:0];
        end
        if (en[2])
        begin
            part_reg <= part_next;
        end
        if (en[3])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (en[4])
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

`default_nettype wire

@@ sv/fractal_iteration_palette_unit.sv @@
// Top level of the fractal iteration palette: iteration count in, packed RGB color out.
`default_nettype none

// Maps each pixel's escape-iteration count to a 24-bit color (red 23:16, green 15:8,
// blue 7:0). While color_ch.ready stays high, one count is taken per cycle and one
// color leaves per cycle. The pipeline is an input stage, then the fraction divider,
// which produces one bit of t = count * 2^FRAC_BITS / (max_iterations + 1) per stage,
// then five stages of exact Bernstein products and one output register. Every stage
// carries a valid bit and holds its item only while the stage after it is full and
// blocked, so bubbles close up and the input keeps taking items while a color waits at
// the output. Configuration (palette_select, max_iterations) is sampled live by the
// stages and may be written only while no item is in flight. A count at or above
// max_iterations gets the palette's interior color; a limit of zero makes every count
// interior.
module fractal_iteration_palette_unit #(
    parameter int ITER_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [fip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fip_pkg::CFG_DATA_W-1:0]  cfg_data,
    fip_iter_if.sink                              iter_ch,
    fip_color_if.source                           color_ch
);

    localparam int RW         = ITER_BITS + 1;
    localparam int POLY_DEPTH = 5;
    // input stage, divider stages, polynomial stages, output register
    localparam int NS         = 1 + FRAC_BITS + POLY_DEPTH + 1;
    localparam int DIV_LO     = 1;
    localparam int POLY_LO    = DIV_LO + FRAC_BITS;
    localparam int OUT_ST     = NS - 1;
    localparam int NB         = (ITER_BITS + 7) / 8;
    localparam int IW8        = NB * 8;

    // per-item data that bypasses the arithmetic
    typedef struct packed {
        logic       interior;
        logic [7:0] residue;   // count mod 255
    } side_t;

    // ---------------------------------------------------------------
    // Configuration registers; the divisor is kept ready as limit + 1
    // ---------------------------------------------------------------
    fip_pkg::palette_t    palette_reg;
    logic [ITER_BITS-1:0] max_iter_reg;
    logic [RW-1:0]        divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg  <= fip_pkg::PAL_GALACTIC;
            max_iter_reg <= ITER_BITS'(fip_pkg::MAX_ITER_RESET);
            divisor_reg  <= RW'(ITER_BITS'(fip_pkg::MAX_ITER_RESET)) + RW'(1);
        end
        else if (cfg_we)
        begin
            unique case (fip_pkg::cfg_index_t'(cfg_index))
                fip_pkg::CFG_PALETTE_SELECT:
                begin
                    palette_reg <= fip_pkg::palette_t'(cfg_data[1:0]);
                end
                fip_pkg::CFG_MAX_ITERATIONS:
                begin
                    max_iter_reg <= ITER_BITS'(cfg_data);
                    divisor_reg  <= RW'(ITER_BITS'(cfg_data)) + RW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage control: a stage loads when it is empty or when every
    // stage after it can move, i.e. there is a hole further down or
    // the output transfer happens this cycle.
    // ---------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] holes;
    logic [NS-1:0] en;

    always_comb
    begin
        holes = ~valid_reg;
        for (int k = 0; k < NS; k++)
        begin
            en[k] = color_ch.ready || (|(holes >> k));
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = iter_ch.valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign iter_ch.ready = en[0];

    // ---------------------------------------------------------------
    // Input stage: interior test, residue for the modular palettes,
    // and the dividend (forced to zero for interior points so the
    // divider never sees a remainder at or above the divisor).
    // ---------------------------------------------------------------
    logic [IW8-1:0] it_wide;
    logic [15:0]    byte_sum;
    side_t          side_in;
    logic [RW-1:0]  dividend_next;
    logic [RW-1:0]  dividend_reg;
    side_t          side_reg [NS-1];

    always_comb
    begin
        it_wide  = IW8'(iter_ch.iteration_count);
        byte_sum = '0;
        for (int b = 0; b < NB; b++)
        begin
            byte_sum = byte_sum + 16'(it_wide[b*8 +: 8]);
        end
        side_in.interior = (iter_ch.iteration_count >= max_iter_reg);
        side_in.residue  = fip_pkg::mod255(byte_sum);
        dividend_next    = side_in.interior ? '0 : {1'b0, iter_ch.iteration_count};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dividend_reg <= dividend_next;
            side_reg[0]  <= side_in;
        end
        for (int k = 1; k < NS - 1; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Fraction t, then the Bernstein color
    // ---------------------------------------------------------------
    logic [FRAC_BITS-1:0] frac_t;
    fip_pkg::rgb_t        poly_color;

    fip_divider #(
        .ITER_BITS (ITER_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .en       (en[POLY_LO-1:DIV_LO]),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (frac_t)
    );

    fip_bernstein #(
        .FRAC_BITS (FRAC_BITS)
    ) u_bernstein (
        .clk   (clk),
        .en    (en[OUT_ST-1:POLY_LO]),
        .t     (frac_t),
        .color (poly_color)
    );

    // ---------------------------------------------------------------
    // Output register: palette selection
    // ---------------------------------------------------------------
    side_t         side_out;
    fip_pkg::rgb_t color_next;
    fip_pkg::rgb_t color_reg;

    always_comb
    begin
        side_out = side_reg[NS-2];
        unique case (palette_reg)
            fip_pkg::PAL_GALACTIC:
            begin
                color_next = side_out.interior ? fip_pkg::INTERIOR_GALACTIC : poly_color;
            end
            fip_pkg::PAL_RED:
            begin
                if (side_out.interior)
                begin
                    color_next = fip_pkg::INTERIOR_RED;
                end
                else
                begin
                    color_next.red   = fip_pkg::mod255_scaled(side_out.residue,
                                                              fip_pkg::RED_PAL_R_STEP);
                    color_next.green = 8'd0;
                    color_next.blue  = fip_pkg::mod255_scaled(side_out.residue,
                                                              fip_pkg::RED_PAL_B_STEP);
                end
            end
            fip_pkg::PAL_PSYCHO:
            begin
                if (side_out.interior)
                begin
                    color_next = fip_pkg::INTERIOR_PSYCHO;
                end
                else
                begin
                    color_next.red   = fip_pkg::mod255_scaled(side_out.residue,
                                                              fip_pkg::PSY_PAL_R_STEP);
                    color_next.green = 8'd0;   // 255*i mod 255
                    color_next.blue  = fip_pkg::mod255_scaled(side_out.residue,
                                                              fip_pkg::PSY_PAL_B_STEP);
                end
            end
            fip_pkg::PAL_BLACK:
            begin
                color_next = fip_pkg::COLOR_BLACK;
            end
            default:
            begin
                color_next = fip_pkg::COLOR_BLACK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_ST])
        begin
            color_reg <= color_next;
        end
    end

    assign color_ch.valid       = valid_reg[OUT_ST];
    assign color_ch.pixel_color = color_reg;

endmodule

`default_nettype wire

@@ test/tb_fractal_iteration_palette_unit.sv @@
// Self-checking testbench for the fractal iteration palette unit.
`timescale 1ns / 1ps

module tb_fractal_iteration_palette_unit;

    // Pipeline depth allowance at the default FRAC_BITS, used to size the settle and idle waits
    localparam int PIPE_DEPTH    = 22;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
    // Slowest sane run is roughly 1800 counts, some under heavy idle pressure, plus drains.
    // This limit leaves an order of magnitude on top of that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENTS      = 14;
    localparam int SEG_COUNTS    = 125;
    localparam int PROBE_ROWS    = 24;

    // One directed probe: configuration, count, and an optional hand-typed color
    typedef struct packed {
        fip_pkg::palette_t pal;
        logic [15:0]       limit;
        logic [15:0]       count;
        logic              typed;
        fip_pkg::rgb_t     color;
    } probe_t;

    // Hand-typed colors are only given where they are obvious: zero fraction, interior
    // points, the black palette, the first step of the modular palettes and a count
    // that wraps the red palette to zero. All other rows go through the predictor.
    localparam probe_t PROBES [PROBE_ROWS] = '{
        // reset configuration: galactic, limit 100
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd0,     1'b1, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd1,     1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd50,    1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd99,    1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd100,   1'b1, fip_pkg::INTERIOR_GALACTIC},
        '{fip_pkg::PAL_GALACTIC, 16'd100,   16'd65535, 1'b1, fip_pkg::INTERIOR_GALACTIC},
        // widest limit: fraction runs right up to the top
        '{fip_pkg::PAL_GALACTIC, 16'd65535, 16'd32767, 1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd65535, 16'd65534, 1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd65535, 16'd65535, 1'b1, fip_pkg::INTERIOR_GALACTIC},
        // smallest nonzero limit
        '{fip_pkg::PAL_GALACTIC, 16'd1,     16'd0,     1'b1, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_GALACTIC, 16'd1,     16'd1,     1'b1, fip_pkg::INTERIOR_GALACTIC},
        // red modular palette
        '{fip_pkg::PAL_RED,      16'd65535, 16'd1,     1'b1, '{8'd12, 8'd0, 8'd6}},
        '{fip_pkg::PAL_RED,      16'd65535, 16'd255,   1'b1, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_RED,      16'd65535, 16'd65534, 1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_RED,      16'd65535, 16'd65535, 1'b1, fip_pkg::INTERIOR_RED},
        // psycho modular palette
        '{fip_pkg::PAL_PSYCHO,   16'd65535, 16'd1,     1'b1, '{8'd128, 8'd0, 8'd64}},
        '{fip_pkg::PAL_PSYCHO,   16'd65535, 16'd43690, 1'b0, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_PSYCHO,   16'd65535, 16'd65535, 1'b1, fip_pkg::INTERIOR_PSYCHO},
        // black palette, interior counts included
        '{fip_pkg::PAL_BLACK,    16'd100,   16'd5,     1'b1, fip_pkg::COLOR_BLACK},
        '{fip_pkg::PAL_BLACK,    16'd100,   16'd65535, 1'b1, fip_pkg::COLOR_BLACK},
        // zero limit: every count is interior
        '{fip_pkg::PAL_GALACTIC, 16'd0,     16'd0,     1'b1, fip_pkg::INTERIOR_GALACTIC},
        '{fip_pkg::PAL_RED,      16'd0,     16'd0,     1'b1, fip_pkg::INTERIOR_RED},
        '{fip_pkg::PAL_PSYCHO,   16'd0,     16'd21845, 1'b1, fip_pkg::INTERIOR_PSYCHO},
        '{fip_pkg::PAL_BLACK,    16'd0,     16'd0,     1'b1, fip_pkg::COLOR_BLACK}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fip_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fip_pkg::CFG_DATA_W-1:0]  cfg_data;

    fip_iter_if #(.ITER_BITS(16)) iter_ch ();
    fip_color_if                  color_ch ();

    fractal_iteration_palette_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .iter_ch  (iter_ch),
        .color_ch (color_ch)
    );

    // Shadow copy of the two registers, as the block should hold them
    fip_pkg::palette_t pal_cfg;
    logic [15:0]       max_cfg;

    // Colors predicted for accepted counts, oldest first
    fip_pkg::rgb_t pending_colors [$];
    fip_pkg::rgb_t oldest_color;
    int            mismatch_count;
    int unsigned   cycle_count;

    // Idle pressure in percent: sender gaps and receiver stalls
    int unsigned gap_pct;
    int unsigned stall_pct;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp_channel(input logic [31:0] v);
        return (v > 32'd255) ? 8'd255 : v[7:0];
    endfunction

    // Color that the block should give a count under the shadow configuration
    function automatic fip_pkg::rgb_t palette_color(input logic [15:0] cnt);
        logic [32:0] scaled;
        logic [16:0] t;
        logic [16:0] u;
        logic [95:0] r_term;
        logic [95:0] g_term;
        logic [95:0] b_term;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        // black wins over everything, interior points included
        if (pal_cfg == fip_pkg::PAL_BLACK)
            return fip_pkg::COLOR_BLACK;
        // a zero limit makes every count interior through this same compare
        if (cnt >= max_cfg)
        begin
            case (pal_cfg)
                fip_pkg::PAL_GALACTIC: return fip_pkg::INTERIOR_GALACTIC;
                fip_pkg::PAL_RED:      return fip_pkg::INTERIOR_RED;
                default:               return fip_pkg::INTERIOR_PSYCHO;
            endcase
        end
        r = '0;
        g = '0;
        b = '0;
        case (pal_cfg)
            fip_pkg::PAL_GALACTIC:
            begin
                // t in Q0.16, strictly below one here since cnt < limit
                scaled = {1'b0, cnt, 16'd0} / (33'(max_cfg) + 33'd1);
                t      = scaled[16:0];
                u      = 17'h10000 - t;
                // exact products, then truncating shifts (blue weight is 17/2)
                r_term = 96'(fip_pkg::K_RED) * u * t * t * t;
                g_term = 96'(fip_pkg::K_GREEN) * u * u * t * t;
                b_term = 96'(fip_pkg::K_BLUE) * u * u * u * t;
                r      = 32'(r_term >> 64);
                g      = 32'(g_term >> 64);
                b      = 32'(b_term >> 65);
            end
            fip_pkg::PAL_RED:
            begin
                r = (32'(cnt) * 32'(fip_pkg::RED_PAL_R_STEP)) % 32'd255;
                b = (32'(cnt) * 32'(fip_pkg::RED_PAL_B_STEP)) % 32'd255;
            end
            default:
            begin
                // psycho: green is 255*i mod 255, always zero
                r = (32'(cnt) * 32'(fip_pkg::PSY_PAL_R_STEP)) % 32'd255;
                b = (32'(cnt) * 32'(fip_pkg::PSY_PAL_B_STEP)) % 32'd255;
            end
        endcase
        return {clamp_channel(r), clamp_channel(g), clamp_channel(b)};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one count and hold it until the transfer happens. valid stays up
    // across back-to-back counts and only drops for a random gap.
    task automatic send_count(input logic [15:0] cnt, input logic typed,
                              input fip_pkg::rgb_t typed_color);
        while ($urandom_range(99) < gap_pct)
        begin
            iter_ch.valid <= 1'b0;
            @(posedge clk);
        end
        iter_ch.valid           <= 1'b1;
        iter_ch.iteration_count <= cnt;
        @(posedge clk);
        while (!iter_ch.ready)
            @(posedge clk);
        // no color can leave in the edge that took the count, so pushing here is safe
        pending_colors.push_back(typed ? typed_color : palette_color(cnt));
    endtask

    // Stop sending and wait until every predicted color has arrived; the extra
    // cycles let the pipeline empty before the registers change.
    task automatic drain_colors();
        iter_ch.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; only called with the pipe empty
    task automatic apply_config(input fip_pkg::palette_t pal, input logic [15:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= fip_pkg::CFG_PALETTE_SELECT;
        cfg_data  <= {{(fip_pkg::CFG_DATA_W-2){1'b0}}, pal};
        @(posedge clk);
        cfg_index <= fip_pkg::CFG_MAX_ITERATIONS;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pal_cfg    = pal;
        max_cfg    = limit;
    endtask

    // Random count biased toward the formula region and the interior boundary
    function automatic logic [15:0] pick_count();
        int unsigned roll;
        int unsigned lo;
        int unsigned hi;
        roll = $urandom_range(99);
        lo   = (max_cfg > 16'd2) ? 32'(max_cfg) - 2 : 0;
        hi   = (max_cfg < 16'd65533) ? 32'(max_cfg) + 2 : 65535;
        if (roll < 60 && max_cfg != 16'd0)
            return 16'($urandom_range(32'(max_cfg) - 1, 0));
        else if (roll < 75)
            return 16'($urandom_range(hi, lo));
        else if (roll < 90)
            return 16'($urandom_range(65535));
        else
            return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // Limit for a random segment: extremes, tiny, the reset value, a small range, or anything
    function automatic logic [15:0] pick_limit();
        case ($urandom_range(6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return fip_pkg::MAX_ITER_RESET;
            4:       return 16'd65535;
            5:       return 16'($urandom_range(300, 2));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready toggles at random per the current stall pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
        color_ch.ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------
    // Checker: every color transfer is matched against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && color_ch.valid && color_ch.ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("pixel_color: none expected, actual %06h", color_ch.pixel_color);
                mismatch_count++;
            end
            else
            begin
                oldest_color = pending_colors.pop_front();
                if (color_ch.pixel_color !== oldest_color)
                begin
                    $error("pixel_color: expected %06h, actual %06h",
                           oldest_color, color_ch.pixel_color);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or lost color ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = fip_pkg::CFG_PALETTE_SELECT;
        cfg_data                = '0;
        iter_ch.valid           = 1'b0;
        iter_ch.iteration_count = '0;
        color_ch.ready          = 1'b0;
        mismatch_count          = 0;
        cycle_count             = 0;
        gap_pct                 = 0;
        stall_pct               = 0;
        // shadow registers start at the reset values
        pal_cfg                 = fip_pkg::PAL_GALACTIC;
        max_cfg                 = fip_pkg::MAX_ITER_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes at full rate. The first rows run on the reset
        // values; registers are only rewritten when a row asks for a change.
        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            if (PROBES[i].pal != pal_cfg || PROBES[i].limit != max_cfg)
            begin
                drain_colors();
                apply_config(PROBES[i].pal, PROBES[i].limit);
            end
            send_count(PROBES[i].count, PROBES[i].typed, PROBES[i].color);
        end

        // Random segments. Each segment gets its own configuration and
        // idle pattern, cycling through: none, sender gaps, receiver stalls,
        // and light pressure on both sides.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_colors();
            case (seg)
                0:       apply_config(fip_pkg::PAL_GALACTIC, 16'd65535);
                1:       apply_config(fip_pkg::PAL_RED, 16'd1);
                2:       apply_config(fip_pkg::PAL_PSYCHO, 16'd0);
                3:       apply_config(fip_pkg::PAL_BLACK, 16'd65535);
                4:       apply_config(fip_pkg::PAL_GALACTIC, 16'd2);
                default: apply_config((seg % 3 == 0) ? fip_pkg::PAL_GALACTIC
                                          : fip_pkg::palette_t'($urandom_range(3)),
                                      pick_limit());
            endcase
            case (seg % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    gap_pct   = 15;
                    stall_pct = 15;
                end
            endcase
            for (int n = 0; n < SEG_COUNTS; n++)
            begin
                // mid-segment hold-off in odd segments: let the pipe run dry
                if (seg % 2 == 1 && n == SEG_COUNTS / 2)
                    drain_colors();
                send_count(pick_count(), 1'b0, fip_pkg::COLOR_BLACK);
            end
        end

        // Everything sent: wait for the last colors, then watch for strays
        drain_colors();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
sv/fip_pkg.sv
sv/fip_iter_if.sv
sv/fip_color_if.sv
sv/fip_divider.sv
sv/fip_bernstein.sv
sv/fractal_iteration_palette_unit.sv
test/tb_fractal_iteration_palette_unit.sv
